FILE: src/addressable_led_frame_sender_assert.svh
// Assertion macros shared by the LED frame sender modules.
// Included by the controller and the datapath; no other dependencies.
`ifndef ADDRESSABLE_LED_FRAME_SENDER_ASSERT_SVH
`define ADDRESSABLE_LED_FRAME_SENDER_ASSERT_SVH

`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define ALFS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("LED frame sender assertion failed");
// A condition in one cycle that implies another in the following cycle.
`define ALFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("LED frame sender assertion failed");
`else
`define ALFS_ASSERT(label, clk, rst_n, prop)
`define ALFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/alfs_pkg.sv
// Shared types and constants for the addressable LED frame sender.
// No dependencies; used by the controller, the datapath and the top level.
package alfs_pkg;

    // Store geometry and field widths.
    localparam int MAX_LEDS  = 128;
    localparam int IDX_W     = 7;
    localparam int COLOUR_W  = 24;
    localparam int CHAN_W    = 8;
    localparam int LED_CNT_W = 8;
    localparam int TICK_W    = 8;
    localparam int BITPOS_W  = 5;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW    = 3'd4;

    // Register values after reset.
    localparam logic [LED_CNT_W-1:0] RST_LED_COUNT = 8'd110;
    localparam logic [TICK_W-1:0]    RST_ZERO_HIGH = 8'd40;
    localparam logic [TICK_W-1:0]    RST_ZERO_LOW  = 8'd85;
    localparam logic [TICK_W-1:0]    RST_ONE_HIGH  = 8'd80;
    localparam logic [TICK_W-1:0]    RST_ONE_LOW   = 8'd45;

    // Command carried by each input transaction.
    typedef enum logic [1:0] {
        KIND_SET_ONE = 2'd0,
        KIND_SET_ALL = 2'd1,
        KIND_START   = 2'd2,
        KIND_TICK    = 2'd3
    } t_kind;

    // Controller states.
    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } t_ctrl_cmd;

endpackage

FILE: src/alfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module alfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/alfs_ctrl.sv
// Controller of the LED frame sender: handshakes and sequencing of each transaction.
// Depends on alfs_pkg and the assertion macro header.
`include "addressable_led_frame_sender_assert.svh"

module alfs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output alfs_pkg::t_ctrl_cmd  o_cmd
);

    alfs_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    // State and output-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= alfs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands. An item is captured in idle, then committed
    // once the output register is free or being emptied.
    always_comb begin
        n_state       = r_state;
        o_s_tready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            alfs_pkg::ST_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.capture = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = alfs_pkg::ST_EXEC;
                end
            end
            alfs_pkg::ST_EXEC: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = alfs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = alfs_pkg::ST_IDLE;
            end
        endcase

        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

    `ALFS_ASSERT_NEXT(a_capture_to_exec, i_clk, i_rst_n, o_cmd.capture, r_state == alfs_pkg::ST_EXEC)
    `ALFS_ASSERT(a_commit_slot_free, i_clk, i_rst_n, o_cmd.commit |-> (!r_out_valid || i_m_tready))
    `ALFS_ASSERT(a_out_from_commit, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(o_cmd.commit))

endmodule

FILE: src/alfs_dp.sv
// Datapath of the LED frame sender: registers, colour store and bit timing.
// Depends on alfs_pkg, alfs_ram and the assertion macro header.
`include "addressable_led_frame_sender_assert.svh"

module alfs_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  alfs_pkg::t_ctrl_cmd                 i_cmd,
    input  logic                                i_cfg_we,
    input  logic [alfs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [alfs_pkg::LED_CNT_W-1:0]      i_cfg_data,
    input  alfs_pkg::t_kind                     i_kind,
    input  logic [alfs_pkg::IDX_W-1:0]          i_led_index,
    input  logic [alfs_pkg::COLOUR_W-1:0]       i_colour,
    output logic                                o_line_level,
    output logic                                o_busy_res,
    output logic                                o_rejected
);

    localparam logic [alfs_pkg::BITPOS_W-1:0] BIT_LAST =
        alfs_pkg::BITPOS_W'(alfs_pkg::COLOUR_W - 1);
    localparam logic [alfs_pkg::LED_CNT_W-1:0] LEN_MAX =
        alfs_pkg::LED_CNT_W'(alfs_pkg::MAX_LEDS);

    // Configuration registers.
    logic [alfs_pkg::LED_CNT_W-1:0] r_led_count;
    logic [alfs_pkg::TICK_W-1:0]    r_zero_high, r_zero_low, r_one_high, r_one_low;

    // Captured item.
    alfs_pkg::t_kind                r_kind;
    logic [alfs_pkg::IDX_W-1:0]     r_index;
    logic [alfs_pkg::COLOUR_W-1:0]  r_colour;

    // Store bookkeeping: an entry without its valid bit reads as the fill colour.
    logic [alfs_pkg::MAX_LEDS-1:0]  r_valid, n_valid;
    logic [alfs_pkg::COLOUR_W-1:0]  r_fill_colour, n_fill_colour;
    logic                           r_rd_valid;

    // Frame state.
    logic                           r_sending, n_sending;
    logic [alfs_pkg::IDX_W-1:0]     r_led_ptr, n_led_ptr;
    logic [alfs_pkg::BITPOS_W-1:0]  r_bit_pos, n_bit_pos;
    logic [alfs_pkg::COLOUR_W-1:0]  r_shift, n_shift;
    logic                           r_in_high, n_in_high;
    logic [alfs_pkg::TICK_W-1:0]    r_timer, n_timer;

    // Result register.
    logic                           r_res_line, r_res_busy, r_res_rej;
    logic                           n_rej;

    logic [alfs_pkg::IDX_W-1:0]     w_rd_addr;
    logic [alfs_pkg::COLOUR_W-1:0]  w_ram_q, w_fetch;
    logic [alfs_pkg::LED_CNT_W-1:0] w_frame_len, w_ptr_next;
    logic [alfs_pkg::TICK_W-1:0]    w_timer_dec;
    logic                           w_ram_we;

    function automatic logic [alfs_pkg::TICK_W-1:0] f_min_one(
        input logic [alfs_pkg::TICK_W-1:0] v
    );
        f_min_one = (v == '0) ? alfs_pkg::TICK_W'(1) : v;
    endfunction

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count <= alfs_pkg::RST_LED_COUNT;
            r_zero_high <= alfs_pkg::RST_ZERO_HIGH;
            r_zero_low  <= alfs_pkg::RST_ZERO_LOW;
            r_one_high  <= alfs_pkg::RST_ONE_HIGH;
            r_one_low   <= alfs_pkg::RST_ONE_LOW;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                alfs_pkg::REG_LED_COUNT: r_led_count <= i_cfg_data;
                alfs_pkg::REG_ZERO_HIGH: r_zero_high <= i_cfg_data;
                alfs_pkg::REG_ZERO_LOW:  r_zero_low  <= i_cfg_data;
                alfs_pkg::REG_ONE_HIGH:  r_one_high  <= i_cfg_data;
                alfs_pkg::REG_ONE_LOW:   r_one_low   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The store read is issued on capture: entry 0 for a frame start,
    // otherwise the LED after the current one.
    assign w_rd_addr = (i_kind == alfs_pkg::KIND_START) ? '0
                                                        : r_led_ptr + alfs_pkg::IDX_W'(1);

    // Capture of the item and of the valid bit of the entry being read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind     <= i_kind;
            r_index    <= i_led_index;
            r_colour   <= i_colour;
            r_rd_valid <= r_valid[w_rd_addr];
        end
    end

    alfs_ram #(
        .WIDTH (alfs_pkg::COLOUR_W),
        .DEPTH (alfs_pkg::MAX_LEDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_index),
        .i_wdata (r_colour),
        .i_re    (i_cmd.capture),
        .i_raddr (w_rd_addr),
        .o_rdata (w_ram_q)
    );

    assign w_fetch     = r_rd_valid ? w_ram_q : r_fill_colour;
    assign w_frame_len = (r_led_count > LEN_MAX) ? LEN_MAX : r_led_count;
    assign w_ptr_next  = alfs_pkg::LED_CNT_W'(r_led_ptr) + alfs_pkg::LED_CNT_W'(1);
    assign w_timer_dec = r_timer - alfs_pkg::TICK_W'(1);

    // Execution of the captured item.
    always_comb begin
        n_valid       = r_valid;
        n_fill_colour = r_fill_colour;
        n_sending     = r_sending;
        n_led_ptr     = r_led_ptr;
        n_bit_pos     = r_bit_pos;
        n_shift       = r_shift;
        n_in_high     = r_in_high;
        n_timer       = r_timer;
        n_rej         = 1'b0;
        case (r_kind)
            alfs_pkg::KIND_SET_ONE: begin
                n_rej = r_sending || (alfs_pkg::LED_CNT_W'(r_index) >= w_frame_len);
                if (!n_rej) begin
                    n_valid[r_index] = 1'b1;
                end
            end
            alfs_pkg::KIND_SET_ALL: begin
                n_rej = r_sending;
                if (!r_sending) begin
                    n_valid       = '0;
                    n_fill_colour = r_colour;
                end
            end
            alfs_pkg::KIND_START: begin
                if (!r_sending && w_frame_len != '0) begin
                    n_sending = 1'b1;
                    n_led_ptr = '0;
                    n_bit_pos = '0;
                    n_shift   = w_fetch;
                    n_in_high = 1'b1;
                    n_timer   = f_min_one(w_fetch[alfs_pkg::COLOUR_W-1] ? r_one_high
                                                                        : r_zero_high);
                end
            end
            alfs_pkg::KIND_TICK: begin
                if (r_sending) begin
                    if (w_timer_dec != '0) begin
                        n_timer = w_timer_dec;
                    end else if (r_in_high) begin
                        // High phase over: low phase of the same bit.
                        n_in_high = 1'b0;
                        n_timer   = f_min_one(r_shift[alfs_pkg::COLOUR_W-1] ? r_one_low
                                                                          : r_zero_low);
                    end else if (r_bit_pos < BIT_LAST) begin
                        // Next bit of the same LED.
                        n_bit_pos = r_bit_pos + alfs_pkg::BITPOS_W'(1);
                        n_shift   = {r_shift[alfs_pkg::COLOUR_W-2:0], 1'b0};
                        n_in_high = 1'b1;
                        n_timer   = f_min_one(r_shift[alfs_pkg::COLOUR_W-2] ? r_one_high
                                                                          : r_zero_high);
                    end else if (w_ptr_next >= w_frame_len || w_ptr_next >= LEN_MAX) begin
                        // Last LED done: the frame ends and the line stays low.
                        n_sending = 1'b0;
                        n_in_high = 1'b0;
                        n_timer   = '0;
                        n_bit_pos = '0;
                        n_led_ptr = w_ptr_next[alfs_pkg::IDX_W-1:0];
                    end else begin
                        // First bit of the next LED.
                        n_bit_pos = '0;
                        n_led_ptr = w_ptr_next[alfs_pkg::IDX_W-1:0];
                        n_shift   = w_fetch;
                        n_in_high = 1'b1;
                        n_timer   = f_min_one(w_fetch[alfs_pkg::COLOUR_W-1] ? r_one_high
                                                                          : r_zero_high);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign w_ram_we = i_cmd.commit && (r_kind == alfs_pkg::KIND_SET_ONE) && !n_rej;

    // Frame and store state registers, updated on commit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_fill_colour <= '0;
            r_sending     <= 1'b0;
            r_led_ptr     <= '0;
            r_bit_pos     <= '0;
            r_shift       <= '0;
            r_in_high     <= 1'b0;
            r_timer       <= '0;
            r_res_line    <= 1'b0;
            r_res_busy    <= 1'b0;
            r_res_rej     <= 1'b0;
        end else if (i_cmd.commit) begin
            r_valid       <= n_valid;
            r_fill_colour <= n_fill_colour;
            r_sending     <= n_sending;
            r_led_ptr     <= n_led_ptr;
            r_bit_pos     <= n_bit_pos;
            r_shift       <= n_shift;
            r_in_high     <= n_in_high;
            r_timer       <= n_timer;
            r_res_line    <= n_sending && n_in_high;
            r_res_busy    <= n_sending;
            r_res_rej     <= n_rej;
        end
    end

    assign o_line_level = r_res_line;
    assign o_busy_res   = r_res_busy;
    assign o_rejected   = r_res_rej;

    `ALFS_ASSERT(a_line_needs_busy, i_clk, i_rst_n, r_res_line |-> r_res_busy)
    `ALFS_ASSERT(a_timer_running, i_clk, i_rst_n, r_sending |-> (r_timer != '0))
    `ALFS_ASSERT_NEXT(a_busy_set_all_dropped, i_clk, i_rst_n, i_cmd.commit && r_sending && (r_kind == alfs_pkg::KIND_SET_ALL), $stable(r_fill_colour))

endmodule

FILE: src/addressable_led_frame_sender.sv
// Top level of the addressable LED frame sender (single-wire RGB strip driver).
// Depends on alfs_pkg, alfs_ctrl, alfs_dp and alfs_ram.
//
// Each input transaction carries one command: set one LED, set all LEDs, start
// a frame, or advance the data line by one tick; each produces exactly one
// result transaction with the line level, the busy flag and a rejected flag.
// The colour store read is issued in the cycle the command is accepted, and its
// registered data is used when the command executes and loads the output
// register. A new command is accepted while the previous result still waits in
// the output register; execution then waits until that register is taken. Set
// all LEDs completes in one command through per-entry valid bits and a fill
// colour, so there is no clearing pass after reset. The user must write the
// configuration registers only while idle; the block does not enforce it.
module addressable_led_frame_sender (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // led_index[6:0], red[14:7], green[22:15], blue[30:23], 0
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // line_level[0], busy_res[1], rejected[2], zeros above
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    alfs_pkg::t_ctrl_cmd               w_cmd;
    logic [alfs_pkg::IDX_W-1:0]        w_led_index;
    logic [alfs_pkg::CHAN_W-1:0]       w_red, w_green, w_blue;
    logic                              w_line, w_busy, w_rej;

    // Unpack the input payload.
    assign w_led_index = s_tdata[6:0];
    assign w_red       = s_tdata[14:7];
    assign w_green     = s_tdata[22:15];
    assign w_blue      = s_tdata[30:23];

    alfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_cmd      (w_cmd)
    );

    alfs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_kind       (alfs_pkg::t_kind'(s_tuser)),
        .i_led_index  (w_led_index),
        .i_colour     ({w_green, w_red, w_blue}),
        .o_line_level (w_line),
        .o_busy_res   (w_busy),
        .o_rejected   (w_rej)
    );

    // Pack the result payload.
    assign m_tdata = {5'b0, w_rej, w_busy, w_line};

endmodule
